// ----- rtl/lsc_pkg.sv -----
// lsc_pkg: shared types and constants for the lru sector cache
// no dependencies; used by lsc_div and lru_sector_cache
package lsc_pkg;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_READ  = 2'd1;

  // percentage division widths: numerator up to (2^32-1)*100, sum of two counts
  localparam int NUM_W = 40;
  localparam int DEN_W = 33;
  localparam int PCT_W = 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN1 = 7'b0000010,
    S_UPDT  = 7'b0000100,
    S_SCAN2 = 7'b0001000,
    S_DIVH  = 7'b0010000,
    S_DIVM  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

// ----- rtl/lsc_div.sv -----
// lsc_div: restoring divider, one quotient bit per cycle, quotient below 128
// depends on lsc_pkg
module lsc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lsc_pkg::NUM_W-1:0]  num,
  input  logic [lsc_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [lsc_pkg::PCT_W-1:0]  quo
);
  import lsc_pkg::*;

  logic [NUM_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [2:0]       k;
  logic             busy;
  logic [NUM_W-1:0] trial;

  assign trial = NUM_W'(den_r) << k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= num;
        den_r <= den;
        k     <= 3'(PCT_W - 1);
        quo   <= '0;
      end else if (busy) begin
        if (rem >= trial) begin
          rem    <= rem - trial;
          quo[k] <= 1'b1;
        end
        if (k == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 3'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/lru_sector_cache.sv -----
// lru_sector_cache: fully associative sector cache with lru replacement
// depends on lsc_pkg and lsc_div
//
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | sector_id, sector_data                  | operation
//  m_*     | out | read_data, hit_percent, miss_percent,   | hit, oldest_valid
//          |     | oldest_sector                           |
//
// each item passes idle, the first scan, the update, the second scan, two divisions and the
// result load; each scan walks max(fill,1) slots, taken before and after the update
// no division runs while no read has been counted
// scans walk one slot per cycle; the percentages share one bit-serial divider
// rst is synchronous and clears counters, fill count and control; entries need no clear
// s_tready is high only when idle; an untaken result holds the sequencer in its final state
module lru_sector_cache #(
  parameter int ENTRIES    = 16,
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // sector_id[31:0], sector_data[95:32]
  input  logic [1:0]   s_tuser,   // operation[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // read_data[63:0], hit_percent[70:64],
                                  // miss_percent[77:71], oldest_sector[109:78], zero
  output logic [1:0]   m_tuser    // hit[0], oldest_valid[1]
);
  import lsc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);

  // entry storage, read at the scan index only
  logic [31:0]           entry_tag   [ENTRIES];
  logic [DATA_WIDTH-1:0] entry_data  [ENTRIES];
  logic [31:0]           entry_stamp [ENTRIES];

  state_t state;
  logic [FW-1:0] fill_count;
  logic [31:0]   access_clock, hit_count, miss_count;

  // captured item
  op_t                   op_r;
  logic [31:0]           id_r;
  logic [DATA_WIDTH-1:0] data_r;

  // scan results
  logic [IW-1:0]         idx, match_idx, best_idx;
  logic                  found;
  logic [DATA_WIDTH-1:0] match_data;
  logic [31:0]           best_stamp, oldest_tag;
  logic [PCT_W-1:0]      hp, mp;

  logic [DEN_W-1:0] total;
  logic [NUM_W-1:0] hit_x100, miss_x100, div_num;
  logic             scan_last, scan2_end;
  logic             div_start, div_done;
  logic [PCT_W-1:0] div_q;
  logic [IW-1:0]    wr_slot;
  logic [31:0]      clock_next;

  assign s_tready = (state == S_IDLE);

  assign total     = DEN_W'(hit_count) + DEN_W'(miss_count);
  // times 100 as 64 + 32 + 4
  assign hit_x100  = (NUM_W'(hit_count) << 6) + (NUM_W'(hit_count) << 5)
                   + (NUM_W'(hit_count) << 2);
  assign miss_x100 = (NUM_W'(miss_count) << 6) + (NUM_W'(miss_count) << 5)
                   + (NUM_W'(miss_count) << 2);
  assign div_num   = (state == S_DIVH) ? miss_x100 : hit_x100;

  assign scan_last = (fill_count == '0) || (FW'(idx) == fill_count - FW'(1));
  assign scan2_end = (state == S_SCAN2) && scan_last;

  // first division starts as the second scan ends, second on the first's done
  assign div_start = (scan2_end && total != '0) || (state == S_DIVH && div_done);

  assign clock_next = access_clock + 32'd1;

  always_comb begin
    if (found)                        wr_slot = match_idx;
    else if (fill_count < FW'(ENTRIES)) wr_slot = IW'(fill_count);
    else                              wr_slot = best_idx;
  end

  lsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (total),
    .done  (div_done),
    .quo   (div_q)
  );

  // entry writes
  always_ff @(posedge clk) begin
    if (state == S_UPDT) begin
      if (op_r == OP_WRITE) begin
        entry_tag[wr_slot]   <= id_r;
        entry_data[wr_slot]  <= data_r;
        entry_stamp[wr_slot] <= clock_next;
      end else if (op_r == OP_READ && found) begin
        entry_stamp[match_idx] <= clock_next;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      access_clock <= '0;
      hit_count    <= '0;
      miss_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // in the final state the load below decides m_tvalid
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r   <= s_tuser;
            id_r   <= s_tdata[31:0];
            data_r <= DATA_WIDTH'(s_tdata[95:32]);
            idx    <= '0;
            found  <= 1'b0;
            state  <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (fill_count != '0) begin
            if (!found && entry_tag[idx] == id_r) begin
              found      <= 1'b1;
              match_idx  <= idx;
              match_data <= entry_data[idx];
            end
            // lowest slot wins on equal stamps
            if (idx == '0 || entry_stamp[idx] < best_stamp) begin
              best_idx   <= idx;
              best_stamp <= entry_stamp[idx];
            end
          end
          if (scan_last) state <= S_UPDT;
          else           idx   <= idx + IW'(1);
        end
        S_UPDT: begin
          if (op_r == OP_WRITE) begin
            access_clock <= clock_next;
            if (!found && fill_count < FW'(ENTRIES)) fill_count <= fill_count + FW'(1);
          end else if (op_r == OP_READ) begin
            access_clock <= clock_next;
            if (found) begin
              if (hit_count != '1) hit_count <= hit_count + 32'd1;
            end else begin
              if (miss_count != '1) miss_count <= miss_count + 32'd1;
            end
          end
          idx   <= '0;
          state <= S_SCAN2;
        end
        S_SCAN2: begin
          if (fill_count == '0) begin
            oldest_tag <= '0;
          end else if (idx == '0 || entry_stamp[idx] < best_stamp) begin
            best_stamp <= entry_stamp[idx];
            oldest_tag <= entry_tag[idx];
          end
          if (scan_last) begin
            if (total != '0) begin
              state <= S_DIVH;
            end else begin
              hp    <= '0;
              mp    <= '0;
              state <= S_DONE;
            end
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_DIVH: begin
          if (div_done) begin
            hp    <= div_q;
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_done) begin
            mp    <= div_q;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // load the output register once the previous result is gone
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, oldest_tag, mp, hp,
                         (op_r == OP_READ && found) ? 64'(match_data) : 64'd0};
            m_tuser  <= {fill_count != '0, found};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the number of slots
  a_fill: assert property (@(posedge clk) disable iff (rst) fill_count <= FW'(ENTRIES))
    else $error("fill count beyond entries");

  // the two percentages of a result never add up past 100
  a_pct: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (8'(m_tdata[70:64]) + 8'(m_tdata[77:71]) <= 8'd100))
    else $error("percentages exceed 100");

  // the divider only reports while the sequencer waits on it
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVH || state == S_DIVM))
    else $error("divider done outside division states");
`endif

endmodule

// ----- verif/tb_lru_sector_cache.sv -----
// tb_lru_sector_cache: self-checking stream testbench for the lru sector cache
// predicts each result with a local cache model; needs lsc_pkg and lru_sector_cache
`timescale 1ns / 1ps

module tb_lru_sector_cache;
  import lsc_pkg::*;

  localparam int N_SLOTS   = 16;
  localparam int WDOG_MAX  = 20000;
  localparam op_t OP_PROBE = 2'd2;
  localparam op_t OP_SPARE = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [31:0] id;
    logic [63:0] data;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] rdata;
    logic [6:0]  hit_pct;
    logic [6:0]  miss_pct;
    logic        old_valid;
    logic [31:0] old_sector;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [1:0] m_tuser;

  lru_sector_cache u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cache shadow
  logic [31:0] sh_tag [N_SLOTS];
  logic [63:0] sh_data [N_SLOTS];
  logic [31:0] sh_stamp [N_SLOTS];
  int unsigned sh_fill;
  logic [31:0] sh_clock, sh_hits, sh_misses;

  access_t  pending_q[$];
  outcome_t expected_q[$];
  int       n_errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       wdog = 0;
  logic [31:0] used_ids[$];

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < sh_fill; i++)
      if (sh_tag[i] == id) return i;
    return -1;
  endfunction

  function automatic int lru_slot();
    int best;
    best = 0;
    for (int i = 1; i < sh_fill; i++)
      if (sh_stamp[i] < sh_stamp[best]) best = i;
    return best;
  endfunction

  function automatic outcome_t cache_access(access_t a);
    outcome_t r;
    int slot, s;
    logic [32:0] total;
    slot = find_slot(a.id);
    r = '0;
    if (a.op == OP_WRITE) begin
      if (slot >= 0) s = slot;
      else if (sh_fill < N_SLOTS) begin
        s = sh_fill;
        sh_fill++;
      end else s = lru_slot();
      sh_clock++;
      sh_tag[s] = a.id;
      sh_data[s] = a.data;
      sh_stamp[s] = sh_clock;
    end else if (a.op == OP_READ) begin
      sh_clock++;
      if (slot >= 0) begin
        r.rdata = sh_data[slot];
        sh_stamp[slot] = sh_clock;
        if (sh_hits != 32'hffff_ffff) sh_hits++;
      end else if (sh_misses != 32'hffff_ffff) sh_misses++;
    end
    total = {1'b0, sh_hits} + {1'b0, sh_misses};
    if (total != 0) begin
      r.hit_pct = 7'(({32'b0, sh_hits} * 64'd100) / {31'b0, total});
      r.miss_pct = 7'(({32'b0, sh_misses} * 64'd100) / {31'b0, total});
    end
    r.hit = (slot >= 0);
    if (sh_fill != 0) begin
      r.old_valid = 1'b1;
      r.old_sector = sh_tag[lru_slot()];
    end
    return r;
  endfunction

  bit s_accept = 0;
  access_t cur;

  always @(posedge clk) begin
    s_accept <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_q.push_back(cache_access(cur));
    end
  end

  // driver: one transfer per accepted item, changes at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_accept) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = pending_q.pop_front();
          s_tdata <= {cur.data, cur.id};
          s_tuser <= cur.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[63:0], m_tdata[70:64], m_tdata[77:71],
               m_tuser[1], m_tdata[109:78]};
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_tdata[111:110] !== 2'b0) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: hit %b/%b rdata %h/%h hpct %0d/%0d mpct %0d/%0d",
                       want.hit, got.hit, want.rdata, got.rdata, want.hit_pct, got.hit_pct,
                       want.miss_pct, got.miss_pct, " old %b:%h/%b:%h",
                       want.old_valid, want.old_sector, got.old_valid, got.old_sector);
          end
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("tb_lru_sector_cache: done, errors");
        $finish;
      end
    end
  end

  task automatic push(op_t op, logic [31:0] id, logic [63:0] data);
    access_t a;
    a.op = op;
    a.id = id;
    a.data = data;
    pending_q.push_back(a);
  endtask

  // most traffic reuses a small id pool so hits, refills and evictions happen
  function automatic logic [31:0] pick_id();
    if (used_ids.size() != 0 && $urandom_range(99) < 75)
      return used_ids[$urandom_range(used_ids.size() - 1)];
    return $urandom >> $urandom_range(31);
  endfunction

  task automatic random_run(int count);
    logic [31:0] id;
    op_t op;
    int pick;
    for (int i = 0; i < count; i++) begin
      id = pick_id();
      if (used_ids.size() < 24) used_ids.push_back(id);
      pick = $urandom_range(99);
      op = (pick < 40) ? OP_WRITE : (pick < 80) ? OP_READ : (pick < 92) ? OP_PROBE : OP_SPARE;
      push(op, id, {$urandom, $urandom});
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    sh_fill = 0;
    sh_clock = '0;
    sh_hits = '0;
    sh_misses = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: empty-cache probe and read, extremes, spare opcode, fill and evict
    push(OP_PROBE, 32'h0, 64'h0);
    push(OP_READ, 32'hffff_ffff, 64'h0);
    push(OP_WRITE, 32'h0, 64'hffff_ffff_ffff_ffff);
    push(OP_WRITE, 32'hffff_ffff, 64'h0);
    push(OP_READ, 32'h0, 64'h1234);
    push(OP_SPARE, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    push(OP_WRITE, 32'h0, 64'ha5a5_5a5a_0f0f_f0f0);
    for (int i = 1; i <= 15; i++) push(OP_WRITE, 32'h100 + i, 64'(i));
    push(OP_WRITE, 32'hdead_beef, 64'h5555_aaaa_5555_aaaa);
    push(OP_READ, 32'hffff_ffff, 64'h0);
    push(OP_PROBE, 32'h0, 64'h0);
    drain();

    // pause until everything is back, then idle/stall phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 30 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 30 : 0;
      random_run(195);
      drain();
    end
    repeat (120) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("tb_lru_sector_cache: done, clean");
    end else begin
      $display("tb_lru_sector_cache: done, errors");
    end
    $finish;
  end

endmodule
